FILE: hw/rtl/rgbl_pkg.sv
package rgbl_pkg;

    // Blink and fade timing, in ticks.
    localparam int FAST_PERIOD = 200;
    localparam int SLOW_PERIOD = 800;
    localparam int FADE_SPAN   = 2 * SLOW_PERIOD;
    localparam int SCALE_DEN   = 255;

    localparam int LEVEL_W = 16;
    localparam int MODE_W  = 3;
    localparam int TICK_W  = 11;
    localparam int STEP_W  = 8;
    localparam int NUM_W   = LEVEL_W + STEP_W;
    localparam int DEN_W   = 10;
    localparam int DCNT_W  = $clog2(NUM_W);
    localparam int NUM_CH  = 3;

    localparam int NUM_REGS  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int PADDR_W   = CFG_IDX_W + 2;

    localparam logic [MODE_W-1:0] MODE_OFF  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ON   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FAST = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SLOW = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FADE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ONCE = 3'd5;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MODE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: hw/rtl/rgbl_cdiv.sv
// Restoring divider, one quotient bit per cycle. The dividend shifts out of
// the top of the register while quotient bits shift in at the bottom.
module rgbl_cdiv (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [rgbl_pkg::NUM_W-1:0]        num,
    input  logic [rgbl_pkg::DEN_W-1:0]        den,
    output logic [rgbl_pkg::NUM_W-1:0]        quot,
    output rgbl_pkg::div_stat_t               stat
);

    logic [rgbl_pkg::NUM_W-1:0]  shf_reg, shf_next;
    logic [rgbl_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [rgbl_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [rgbl_pkg::DEN_W:0]    trial;
    logic                        fits;

    assign trial = {rem_reg, shf_reg[rgbl_pkg::NUM_W-1]};
    assign fits  = (trial >= {1'b0, den});

    always_comb begin
        shf_next  = shf_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            shf_next  = num;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rgbl_pkg::DEN_W'(trial - {1'b0, den});
            end else begin
                rem_next = trial[rgbl_pkg::DEN_W-1:0];
            end
            shf_next = {shf_reg[rgbl_pkg::NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rgbl_pkg::DCNT_W'(rgbl_pkg::NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        shf_reg <= shf_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quot      = shf_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: hw/rtl/rgb_led_blink_fade_controller_top.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+------------------------------------------
// s_        | in        | s_tvalid / s_tready  | tuser: cmd; tdata: new_mode
// m_        | out       | m_tvalid / m_tready  | tdata: red_level, green_level, blue_level
// APB       | in        | psel/penable/pwrite  | colour registers at 0x0, 0x4, 0x8
//
// A mode request or a tick outside fade mode gives its result in the cycle after
// acceptance. A tick in fade mode runs a step division on lane 0, a product, a
// launch and a scaling division on all three lanes, each division bit-serial at
// one quotient bit per cycle. Reset is synchronous and active low. A new transaction
// is taken only when the block is idle and the output register is empty or being
// emptied; a stalled result holds in the output register.
module rgb_led_blink_fade_controller_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [2:0] new_mode
    input  logic [0:0]                      s_tuser,   // [0] cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,   // [15:0] red_level, [31:16] green_level,
                                                       // [47:32] blue_level
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rgbl_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_MUL,
        ST_LAUNCH,
        ST_SCALE,
        ST_HOLD
    } state_t;

    state_t st_reg;

    logic [rgbl_pkg::LEVEL_W-1:0] color_reg [rgbl_pkg::NUM_CH];
    logic [rgbl_pkg::LEVEL_W-1:0] level_reg [rgbl_pkg::NUM_CH];
    logic [rgbl_pkg::LEVEL_W-1:0] level_next [rgbl_pkg::NUM_CH];
    logic [rgbl_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic [rgbl_pkg::MODE_W-1:0]  before_reg, before_next;
    logic                         pend_reg, pend_next;
    logic [rgbl_pkg::TICK_W-1:0]  tick_reg, tick_next;
    logic                         phase_reg, phase_next;
    logic [rgbl_pkg::STEP_W-1:0]  step_reg;
    logic [rgbl_pkg::NUM_W-1:0]   prod_reg [rgbl_pkg::NUM_CH];
    logic                         m_tvalid_reg;
    logic [47:0]                  m_tdata_reg;

    logic                         s_accept;
    logic                         out_free;
    logic                         cfg_write;
    logic [rgbl_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic                         fade_go;
    logic [rgbl_pkg::TICK_W-1:0]  lvl;
    logic [rgbl_pkg::NUM_W-1:0]   step_num;

    logic [rgbl_pkg::NUM_W-1:0]   div_num  [rgbl_pkg::NUM_CH];
    logic [rgbl_pkg::NUM_W-1:0]   div_quot [rgbl_pkg::NUM_CH];
    logic [rgbl_pkg::DEN_W-1:0]   div_den  [rgbl_pkg::NUM_CH];
    logic                         div_start [rgbl_pkg::NUM_CH];
    rgbl_pkg::div_stat_t          div_stat [rgbl_pkg::NUM_CH];
    logic                         launch;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (st_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[rgbl_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            rgbl_pkg::REG_RED:   prdata = {16'd0, color_reg[0]};
            rgbl_pkg::REG_GREEN: prdata = {16'd0, color_reg[1]};
            rgbl_pkg::REG_BLUE:  prdata = {16'd0, color_reg[2]};
            default:             prdata = '0;
        endcase
    end

    // Next architectural state for an accepted transaction, a finished fade scale or a colour write.
    always_comb begin
        mode_next   = mode_reg;
        before_next = before_reg;
        pend_next   = pend_reg;
        tick_next   = tick_reg;
        phase_next  = phase_reg;
        level_next  = level_reg;
        fade_go     = 1'b0;
        lvl         = '0;
        if (s_accept) begin
            if (s_tuser[0] == rgbl_pkg::CMD_MODE) begin
                if (s_tdata[2:0] <= rgbl_pkg::MODE_ONCE) begin
                    before_next = mode_reg;
                    mode_next   = s_tdata[2:0];
                    pend_next   = 1'b1;
                end
            end else begin
                tick_next = tick_reg + 1'b1;
                if (pend_reg) begin
                    pend_next = 1'b0;
                    case (mode_reg)
                        rgbl_pkg::MODE_OFF: begin
                            level_next = '{default: '0};
                        end
                        rgbl_pkg::MODE_ON: begin
                            level_next = color_reg;
                        end
                        rgbl_pkg::MODE_FAST, rgbl_pkg::MODE_SLOW: begin
                            tick_next  = '0;
                            phase_next = 1'b1;
                            level_next = color_reg;
                        end
                        rgbl_pkg::MODE_ONCE: begin
                            tick_next  = '0;
                            phase_next = 1'b0;
                            level_next = '{default: '0};
                        end
                        default: begin
                        end
                    endcase
                end
                case (mode_reg)
                    rgbl_pkg::MODE_FAST, rgbl_pkg::MODE_SLOW: begin
                        if ((mode_reg == rgbl_pkg::MODE_FAST &&
                             tick_next >= rgbl_pkg::TICK_W'(rgbl_pkg::FAST_PERIOD)) ||
                            (mode_reg == rgbl_pkg::MODE_SLOW &&
                             tick_next >= rgbl_pkg::TICK_W'(rgbl_pkg::SLOW_PERIOD))) begin
                            tick_next = '0;
                            if (phase_next) begin
                                level_next = color_reg;
                                phase_next = 1'b0;
                            end else begin
                                level_next = '{default: '0};
                                phase_next = 1'b1;
                            end
                        end
                    end
                    rgbl_pkg::MODE_FADE: begin
                        if (tick_next >= rgbl_pkg::TICK_W'(rgbl_pkg::FADE_SPAN)) begin
                            tick_next = '0;
                        end
                        if (tick_next < rgbl_pkg::TICK_W'(rgbl_pkg::SLOW_PERIOD)) begin
                            lvl = tick_next;
                        end else begin
                            lvl = rgbl_pkg::TICK_W'(rgbl_pkg::FADE_SPAN) - tick_next;
                        end
                        fade_go = 1'b1;
                    end
                    rgbl_pkg::MODE_ONCE: begin
                        if (tick_next >= rgbl_pkg::TICK_W'(rgbl_pkg::FAST_PERIOD)) begin
                            tick_next = '0;
                            if (phase_next) begin
                                before_next = mode_reg;
                                mode_next   = before_reg;
                                pend_next   = 1'b1;
                            end else begin
                                level_next = '{default: '0};
                                phase_next = 1'b1;
                            end
                        end
                    end
                    default: begin
                        tick_next = '0;
                    end
                endcase
            end
        end
        if (st_reg == ST_SCALE && div_stat[0].done) begin
            for (int i = 0; i < rgbl_pkg::NUM_CH; i++) begin
                level_next[i] = div_quot[i][rgbl_pkg::LEVEL_W-1:0];
            end
        end
        // A colour write takes effect through the same path as a mode request.
        if (cfg_write && cfg_idx < rgbl_pkg::CFG_IDX_W'(rgbl_pkg::NUM_REGS)) begin
            pend_next = 1'b1;
        end
    end

    // step numerator is lvl * 255, formed as a shift and a subtract.
    assign step_num = (rgbl_pkg::NUM_W'(lvl) << rgbl_pkg::STEP_W) - rgbl_pkg::NUM_W'(lvl);
    assign launch   = (st_reg == ST_LAUNCH);

    // Lane 0 divides by the slow period while the step is formed and by 255
    // while it scales the red level, so its divisor follows the sequencer.
    always_comb begin
        for (int i = 0; i < rgbl_pkg::NUM_CH; i++) begin
            div_num[i]   = prod_reg[i];
            div_den[i]   = rgbl_pkg::DEN_W'(rgbl_pkg::SCALE_DEN);
            div_start[i] = launch;
        end
        if (st_reg == ST_IDLE || st_reg == ST_STEP) begin
            div_num[0] = step_num;
            div_den[0] = rgbl_pkg::DEN_W'(rgbl_pkg::SLOW_PERIOD);
            div_start[0] = fade_go;
        end
    end

    for (genvar g = 0; g < rgbl_pkg::NUM_CH; g++) begin : g_lane
        rgbl_cdiv u_cdiv (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (div_start[g]),
            .num     (div_num[g]),
            .den     (div_den[g]),
            .quot    (div_quot[g]),
            .stat    (div_stat[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg  <= '{default: '0};
            level_reg  <= '{default: '0};
            mode_reg   <= rgbl_pkg::MODE_OFF;
            before_reg <= rgbl_pkg::MODE_OFF;
            pend_reg   <= 1'b0;
            tick_reg   <= '0;
            phase_reg  <= 1'b0;
        end else begin
            level_reg  <= level_next;
            mode_reg   <= mode_next;
            before_reg <= before_next;
            pend_reg   <= pend_next;
            tick_reg   <= tick_next;
            phase_reg  <= phase_next;
            if (cfg_write && cfg_idx < rgbl_pkg::CFG_IDX_W'(rgbl_pkg::NUM_REGS)) begin
                color_reg[cfg_idx] <= pwdata[rgbl_pkg::LEVEL_W-1:0];
            end
        end
    end

    // Sequencer for the fade arithmetic and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (st_reg)
                ST_IDLE: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (s_accept) begin
                        if (fade_go) begin
                            st_reg <= ST_STEP;
                        end else begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= {level_next[2], level_next[1], level_next[0]};
                        end
                    end
                end
                ST_STEP: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (div_stat[0].done) begin
                        step_reg <= div_quot[0][rgbl_pkg::STEP_W-1:0];
                        st_reg   <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                    for (int i = 0; i < rgbl_pkg::NUM_CH; i++) begin
                        prod_reg[i] <= rgbl_pkg::NUM_W'(color_reg[i]) *
                                       rgbl_pkg::NUM_W'(step_reg);
                    end
                    st_reg <= ST_LAUNCH;
                end
                ST_LAUNCH: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                    st_reg <= ST_SCALE;
                end
                ST_SCALE: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (div_stat[0].done) begin
                        if (out_free) begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= {level_next[2], level_next[1], level_next[0]};
                            st_reg       <= ST_IDLE;
                        end else begin
                            st_reg <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {level_reg[2], level_reg[1], level_reg[0]};
                        st_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat[0].done |-> (st_reg == ST_STEP || st_reg == ST_SCALE))
        else $error("divider finished outside a divide state");

    a_lanes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_SCALE) |->
            (div_stat[0].done == div_stat[1].done && div_stat[0].done == div_stat[2].done))
        else $error("scale lanes finished at different cycles");

    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_IDLE) |-> !div_stat[0].busy)
        else $error("divider busy while sequencer idle");

    a_hold_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_HOLD) |-> m_tvalid_reg)
        else $error("waiting for output space with an empty output register");
`endif

endmodule

FILE: dv/rgb_led_blink_fade_controller_top_tb.sv
module rgb_led_blink_fade_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned PHASE_ITEMS  = 45;

    // Address slot past the colour registers; writes there must be dropped.
    localparam logic [rgbl_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata  = '0;   // [2:0] new_mode
    logic [0:0]                     s_tuser  = '0;   // [0] cmd
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [47:0]                    m_tdata;         // [15:0] red, [31:16] green, [47:32] blue
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [rgbl_pkg::PADDR_W-1:0]   paddr    = '0;
    logic [31:0]                    pwdata   = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    // Shadow of the controller state, advanced on every accepted transaction.
    logic [rgbl_pkg::LEVEL_W-1:0]   colour     [rgbl_pkg::NUM_CH];
    logic [rgbl_pkg::LEVEL_W-1:0]   held_level [rgbl_pkg::NUM_CH];
    logic [rgbl_pkg::MODE_W-1:0]    cur_mode;
    logic [rgbl_pkg::MODE_W-1:0]    prev_mode;
    logic                           mode_dirty;
    logic                           blink_phase;
    logic [rgbl_pkg::TICK_W-1:0]    tick_cnt;

    logic [3*rgbl_pkg::LEVEL_W-1:0] level_queue [$];
    string                          level_names [rgbl_pkg::NUM_CH] =
                                        '{"red_level", "green_level", "blue_level"};

    int                     fail_count    = 0;
    int                     items_sent    = 0;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     hold_token    = 0;
    int                     hold_seen     = 0;
    int unsigned            hold_left     = 0;
    int unsigned            cycle_count   = 0;

    rgb_led_blink_fade_controller_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic void lights_dark();
        int ch;
        for (ch = 0; ch < rgbl_pkg::NUM_CH; ch++) held_level[ch] = '0;
    endfunction

    function automatic void lights_lit();
        int ch;
        for (ch = 0; ch < rgbl_pkg::NUM_CH; ch++) held_level[ch] = colour[ch];
    endfunction

    function automatic void blink_step(input int unsigned period);
        if (tick_cnt >= period) begin
            tick_cnt = '0;
            if (blink_phase) begin
                lights_lit();
                blink_phase = 1'b0;
            end else begin
                lights_dark();
                blink_phase = 1'b1;
            end
        end
    endfunction

    function automatic void predict_levels(input logic cmd,
                                           input logic [rgbl_pkg::MODE_W-1:0] req);
        logic [rgbl_pkg::MODE_W-1:0] back;
        int unsigned                 ramp;
        int unsigned                 frac;
        int                          ch;
        if (cmd == rgbl_pkg::CMD_TICK) begin
            tick_cnt = tick_cnt + 1'b1;
            if (mode_dirty) begin
                mode_dirty = 1'b0;
                case (cur_mode)
                    rgbl_pkg::MODE_OFF: lights_dark();
                    rgbl_pkg::MODE_ON:  lights_lit();
                    rgbl_pkg::MODE_FAST, rgbl_pkg::MODE_SLOW: begin
                        tick_cnt    = '0;
                        blink_phase = 1'b1;
                        lights_lit();
                    end
                    rgbl_pkg::MODE_ONCE: begin
                        tick_cnt    = '0;
                        blink_phase = 1'b0;
                        lights_dark();
                    end
                    default: ;
                endcase
            end
            case (cur_mode)
                rgbl_pkg::MODE_FAST: blink_step(rgbl_pkg::FAST_PERIOD);
                rgbl_pkg::MODE_SLOW: blink_step(rgbl_pkg::SLOW_PERIOD);
                rgbl_pkg::MODE_FADE: begin
                    if (tick_cnt >= rgbl_pkg::FADE_SPAN) tick_cnt = '0;
                    ramp = (tick_cnt < rgbl_pkg::SLOW_PERIOD) ? tick_cnt :
                                                                rgbl_pkg::FADE_SPAN - tick_cnt;
                    frac = ramp * rgbl_pkg::SCALE_DEN / rgbl_pkg::SLOW_PERIOD;
                    for (ch = 0; ch < rgbl_pkg::NUM_CH; ch++) begin
                        held_level[ch] = rgbl_pkg::LEVEL_W'((colour[ch] * frac) /
                                                           rgbl_pkg::SCALE_DEN);
                    end
                end
                rgbl_pkg::MODE_ONCE: begin
                    if (tick_cnt >= rgbl_pkg::FAST_PERIOD) begin
                        tick_cnt = '0;
                        if (blink_phase) begin
                            // The flash is over: hand back to the mode it interrupted.
                            back       = prev_mode;
                            prev_mode  = cur_mode;
                            cur_mode   = back;
                            mode_dirty = 1'b1;
                        end else begin
                            lights_dark();
                            blink_phase = 1'b1;
                        end
                    end
                end
                default: tick_cnt = '0;
            endcase
        end else if (req <= rgbl_pkg::MODE_ONCE) begin
            prev_mode  = cur_mode;
            cur_mode   = req;
            mode_dirty = 1'b1;
        end
    endfunction

    // Results are checked before inputs are predicted, as a result can never
    // belong to a transaction accepted at the same edge.
    always @(posedge aclk) begin : level_monitor
        logic [3*rgbl_pkg::LEVEL_W-1:0] want;
        int                             ch;
        if (!aresetn) begin
            for (ch = 0; ch < rgbl_pkg::NUM_CH; ch++) begin
                colour[ch]     = '0;
                held_level[ch] = '0;
            end
            cur_mode    = rgbl_pkg::MODE_OFF;
            prev_mode   = rgbl_pkg::MODE_OFF;
            mode_dirty  = 1'b0;
            blink_phase = 1'b0;
            tick_cnt    = '0;
            level_queue.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (level_queue.size() == 0) begin
                    $error("unexpected result transaction: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = level_queue.pop_front();
                    for (ch = 0; ch < rgbl_pkg::NUM_CH; ch++) begin
                        if (m_tdata[ch*rgbl_pkg::LEVEL_W +: rgbl_pkg::LEVEL_W] !==
                            want[ch*rgbl_pkg::LEVEL_W +: rgbl_pkg::LEVEL_W]) begin
                            $error("%s: expected %h, got %h", level_names[ch],
                                   want[ch*rgbl_pkg::LEVEL_W +: rgbl_pkg::LEVEL_W],
                                   m_tdata[ch*rgbl_pkg::LEVEL_W +: rgbl_pkg::LEVEL_W]);
                            fail_count++;
                        end
                    end
                end
            end
            if (psel && penable && pwrite && pready &&
                paddr[rgbl_pkg::PADDR_W-1:2] <= rgbl_pkg::REG_BLUE) begin
                colour[paddr[rgbl_pkg::PADDR_W-1:2]] = pwdata[rgbl_pkg::LEVEL_W-1:0];
                mode_dirty = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                predict_levels(s_tuser[0], s_tdata[rgbl_pkg::MODE_W-1:0]);
                level_queue.push_back({held_level[2], held_level[1], held_level[0]});
            end
        end
    end

    // Result side: random stalls, or a long hold-off when a new token arrives.
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rgb_led_blink_fade_controller_top_tb: FAIL");
            $finish;
        end
    end

    function automatic logic [rgbl_pkg::LEVEL_W-1:0] pick_colour();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            default: return rgbl_pkg::LEVEL_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [rgbl_pkg::MODE_W-1:0] req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(8-rgbl_pkg::MODE_W){1'b0}}, req};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(rgbl_pkg::CMD_TICK, rgbl_pkg::MODE_W'($urandom_range(7)));
    endtask

    task automatic request_mode(input logic [rgbl_pkg::MODE_W-1:0] req);
        send_item(rgbl_pkg::CMD_MODE, req);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (level_queue.size() != 0) @(posedge aclk);
    endtask

    task automatic write_colour(input logic [rgbl_pkg::CFG_IDX_W-1:0] idx,
                                input logic [rgbl_pkg::LEVEL_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_colour(input logic [rgbl_pkg::CFG_IDX_W-1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {16'h0000, colour[idx]}) begin
            $error("prdata: expected %h, got %h", {16'h0000, colour[idx]}, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_colours(input logic [rgbl_pkg::LEVEL_W-1:0] red,
                               input logic [rgbl_pkg::LEVEL_W-1:0] green,
                               input logic [rgbl_pkg::LEVEL_W-1:0] blue);
        wait_drain();
        write_colour(rgbl_pkg::REG_RED, red);
        write_colour(rgbl_pkg::REG_GREEN, green);
        write_colour(rgbl_pkg::REG_BLUE, blue);
        check_colour(rgbl_pkg::REG_RED);
        check_colour(rgbl_pkg::REG_GREEN);
        check_colour(rgbl_pkg::REG_BLUE);
    endtask

    task automatic test_reset_state();
        check_colour(rgbl_pkg::REG_RED);
        check_colour(rgbl_pkg::REG_GREEN);
        check_colour(rgbl_pkg::REG_BLUE);
        send_ticks(2);
        request_mode(rgbl_pkg::MODE_ON);
        send_ticks(1);
    endtask

    task automatic test_directed();
        set_colours(16'hFFFF, 16'h0000, 16'h8001);
        send_ticks(1);
        request_mode(rgbl_pkg::MODE_ON);
        send_ticks(1);
        // Codes past the last mode must leave everything alone.
        request_mode(3'd6);
        request_mode(3'd7);
        send_ticks(1);
        request_mode(rgbl_pkg::MODE_FADE);
        send_ticks(2);
        request_mode(rgbl_pkg::MODE_FAST);
        send_ticks(2);
        request_mode(rgbl_pkg::MODE_SLOW);
        send_ticks(1);
        request_mode(rgbl_pkg::MODE_ONCE);
        send_ticks(1);
        request_mode(rgbl_pkg::MODE_OFF);
        send_ticks(1);
        request_mode(rgbl_pkg::MODE_ON);
        request_mode(rgbl_pkg::MODE_FADE);
        send_ticks(2);
    endtask

    task automatic test_colour_writes();
        set_colours(16'h0000, 16'h0000, 16'h0000);
        request_mode(rgbl_pkg::MODE_ON);
        send_ticks(2);
        set_colours(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_ticks(2);
        // A colour write re-arms the pending change, which restarts a blink.
        request_mode(rgbl_pkg::MODE_FAST);
        send_ticks(5);
        wait_drain();
        write_colour(rgbl_pkg::REG_GREEN, 16'h1234);
        send_ticks(3);
        wait_drain();
        write_colour(REG_SPARE, 16'hA5A5);
        send_ticks(3);
        set_colours(16'h0001, 16'h8000, 16'h7FFF);
        request_mode(rgbl_pkg::MODE_FADE);
        send_ticks(4);
        set_colours(pick_colour(), pick_colour(), pick_colour());
        request_mode(rgbl_pkg::MODE_ON);
        send_ticks(2);
    endtask

    task automatic test_long_periods();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        set_colours(16'hFFFF, pick_colour(), rgbl_pkg::LEVEL_W'($urandom));
        // Run fast blink through both halves of its cycle, so that the lit
        // and the dark toggle are each taken once.
        request_mode(rgbl_pkg::MODE_FAST);
        send_ticks(2 * rgbl_pkg::FAST_PERIOD + 2);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        request_mode(rgbl_pkg::MODE_ON);
        hold_token <= hold_token + 1;
        repeat (6) begin
            send_ticks(1);
            request_mode(rgbl_pkg::MODE_W'($urandom_range(rgbl_pkg::MODE_OFF,
                                                          rgbl_pkg::MODE_SLOW)));
        end
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int phase;
        int target;
        int seq;
        int run_len;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 37;
                    recv_idle_pct <= 47;
                end
                1: begin
                    send_idle_pct = 47;
                    recv_idle_pct <= 37;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            target = items_sent + PHASE_ITEMS;
            seq    = 0;
            while (items_sent < target) begin
                seq++;
                if (seq % 7 == 0) begin
                    wait_drain();
                    if ($urandom_range(4) == 0) begin
                        write_colour(REG_SPARE, rgbl_pkg::LEVEL_W'($urandom));
                    end else begin
                        write_colour(rgbl_pkg::CFG_IDX_W'($urandom_range(rgbl_pkg::REG_RED,
                                                                         rgbl_pkg::REG_BLUE)),
                                     pick_colour());
                    end
                end
                if ($urandom_range(9) == 0) begin
                    request_mode(rgbl_pkg::MODE_W'($urandom_range(6, 7)));
                end else begin
                    request_mode(rgbl_pkg::MODE_W'($urandom_range(rgbl_pkg::MODE_OFF,
                                                                  rgbl_pkg::MODE_ONCE)));
                end
                if ($urandom_range(6) == 0) begin
                    request_mode(rgbl_pkg::MODE_W'($urandom_range(rgbl_pkg::MODE_OFF,
                                                                  rgbl_pkg::MODE_ONCE)));
                end
                case ($urandom_range(19))
                    0:       run_len = $urandom_range(40, 120);
                    1, 2, 3: run_len = $urandom_range(10, 40);
                    default: run_len = $urandom_range(1, 20);
                endcase
                send_ticks(run_len);
            end
        end
    endtask

    initial begin
        send_idle_pct = 37;
        recv_idle_pct <= 47;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_directed();
        test_colour_writes();
        test_long_periods();
        test_backpressure();
        test_random_traffic();
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (level_queue.size() != 0) begin
            $error("%0d result transactions never arrived", level_queue.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("rgb_led_blink_fade_controller_top_tb: PASS");
        end else begin
            $display("rgb_led_blink_fade_controller_top_tb: FAIL");
        end
        $finish;
    end

endmodule
